// File: hdl/attitude_frame_builder_crc16_macros.svh
// Assertion macros for the attitude frame builder checker.
`ifndef ATTITUDE_FRAME_BUILDER_CRC16_MACROS_SVH
`define ATTITUDE_FRAME_BUILDER_CRC16_MACROS_SVH

// Same-cycle implication, sampled on clk and idle while rst_n is low.
`define AFB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and idle while rst_n is low.
`define AFB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/afb_pkg.sv
// Constants, stage types and the CRC-16/MODBUS byte step for the frame builder.
package afb_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'h66;
    localparam logic [7:0] LEN_SHORT = 8'd11;
    localparam logic [7:0] LEN_LONG  = 8'd17;
    localparam logic [7:0] TAIL_A    = 8'h11;
    localparam logic [7:0] TAIL_B    = 8'h22;
    localparam logic [7:0] PAD_BYTE  = 8'h00;

    localparam logic signed [7:0] QUAT_SCALE = 8'sd100;
    localparam int QUAT_W   = 16;
    localparam int QUAT_FRAC = 14;
    localparam int QP_W     = 23;
    localparam int EULER_W  = 25;
    localparam int EULER_FRAC = 16;
    localparam int DEG_W    = EULER_W - EULER_FRAC;
    localparam logic [QP_W:0] QUAT_BIAS = (QP_W + 1)'((1 << QUAT_FRAC) - 1);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam int FRAME_MAX   = 19;
    localparam int FRAME_SHORT = 13;
    localparam int CNT_W       = $clog2(FRAME_MAX + 1);

    typedef logic [0:0] cfg_index_t;
    localparam cfg_index_t CFG_DEVICE_ADDRESS = 1'b0;
    localparam cfg_index_t CFG_LONG_FRAME     = 1'b1;

    // First stage: scaled quaternion products and whole-degree angles.
    typedef struct packed {
        logic [3:0][QP_W-1:0] qp;
        logic [2:0][15:0]     ang;
        logic [1:0]           acc;
        logic                 rev;
    } s1_t;

    // Later stages: quaternion bytes and the running CRC.
    typedef struct packed {
        logic [3:0][7:0]  qb;
        logic [2:0][15:0] ang;
        logic [1:0]       acc;
        logic             rev;
        logic [15:0]      crc;
    } sq_t;

    typedef logic [FRAME_MAX-1:0][7:0] frame_t;

    function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                               input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: hdl/attitude_frame_builder_crc16.sv
// A sample passes through the stage 1, 2 and 3 registers into the output shift register.
// The shift register sends one byte per cycle while out_ready is high; a frame is 13
// bytes (short frame) or 19 bytes (long frame).
// The three compute stages and the shift register overlap, so frames leave gap-free.
// Reset clears all stage valid bits and the byte count, and sets address 1, short frame.
module attitude_frame_builder_crc16
    import afb_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  cfg_index_t                 cfg_index,
    input  logic [7:0]                 cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [QUAT_W-1:0]   quat_w,
    input  logic signed [QUAT_W-1:0]   quat_x,
    input  logic signed [QUAT_W-1:0]   quat_y,
    input  logic signed [QUAT_W-1:0]   quat_z,
    input  logic signed [EULER_W-1:0]  euler_a,
    input  logic signed [EULER_W-1:0]  euler_b,
    input  logic signed [EULER_W-1:0]  euler_c,
    input  logic [1:0]                 fusion_accuracy,
    input  logic                       reverse_flag,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [7:0]                 frame_byte,
    output logic                       last_byte
);

    logic [7:0]       device_address_reg;
    logic             long_frame_reg;

    logic             s1_valid_reg;
    logic             s2_valid_reg;
    logic             s3_valid_reg;
    s1_t              s1_reg;
    s1_t              s1_next;
    sq_t              s2_reg;
    sq_t              s2_next;
    sq_t              s3_reg;
    sq_t              s3_next;

    frame_t           sh_reg;
    frame_t           sh_next;
    frame_t           load_frame;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] load_cnt;

    logic             ser_free;
    logic             s3_open;
    logic             s2_open;
    logic             s1_open;
    logic             s3_adv;
    logic             out_fire;
    logic [7:0]       len_byte;

    logic [3:0][QUAT_W-1:0]  quat_in;
    logic [2:0][EULER_W-1:0] euler_in;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg <= 8'd1;
            long_frame_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEVICE_ADDRESS: device_address_reg <= cfg_data;
                CFG_LONG_FRAME:     long_frame_reg     <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    assign len_byte = long_frame_reg ? LEN_LONG : LEN_SHORT;

    // Stall chain: a stage takes a new word when it is empty or its word moves on.
    assign out_valid  = (cnt_reg != '0);
    assign out_fire   = out_valid && out_ready;
    assign frame_byte = sh_reg[0];
    assign last_byte  = (cnt_reg == CNT_W'(1));
    assign ser_free   = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && out_ready);
    assign s3_open    = !s3_valid_reg || ser_free;
    assign s3_adv     = s3_valid_reg && ser_free;
    assign s2_open    = !s2_valid_reg || s3_open;
    assign s1_open    = !s1_valid_reg || s2_open;
    assign in_ready   = s1_open;

    // Stage 1: quaternion times 100 and angles truncated toward zero.
    always_comb
    begin
        logic [DEG_W-1:0] deg;
        quat_in  = {quat_z, quat_y, quat_x, quat_w};
        euler_in = {euler_c, euler_b, euler_a};
        s1_next.acc = fusion_accuracy;
        s1_next.rev = reverse_flag;
        for (int i = 0; i < 4; i++)
        begin
            s1_next.qp[i] = QP_W'($signed({{(QP_W - QUAT_W){quat_in[i][QUAT_W-1]}},
                                            quat_in[i]}) * QUAT_SCALE);
        end
        for (int i = 0; i < 3; i++)
        begin
            // Floor shift, then one up for a negative value with a fraction.
            deg = euler_in[i][EULER_W-1:EULER_FRAC]
                + DEG_W'(euler_in[i][EULER_W-1] && (euler_in[i][EULER_FRAC-1:0] != '0));
            s1_next.ang[i] = {{(16 - DEG_W){deg[DEG_W-1]}}, deg};
        end
    end

    // Stage 2: divide by 16384 toward zero, CRC over the three header bytes.
    always_comb
    begin
        logic [QP_W:0] sum;
        s2_next.ang = s1_reg.ang;
        s2_next.acc = s1_reg.acc;
        s2_next.rev = s1_reg.rev;
        for (int i = 0; i < 4; i++)
        begin
            sum = {s1_reg.qp[i][QP_W-1], s1_reg.qp[i]}
                + (s1_reg.qp[i][QP_W-1] ? QUAT_BIAS : '0);
            s2_next.qb[i] = sum[QUAT_FRAC+7:QUAT_FRAC];
        end
        s2_next.crc = crc_update(crc_update(crc_update(CRC_INIT, SYNC_BYTE),
                                            device_address_reg), len_byte);
    end

    // Stage 3: CRC over the quaternion bytes and the accuracy byte.
    always_comb
    begin
        logic [15:0] c;
        s3_next = s2_reg;
        c = s2_reg.crc;
        for (int i = 0; i < 4; i++)
        begin
            c = crc_update(c, s2_reg.qb[i]);
        end
        s3_next.crc = crc_update(c, {6'b0, s2_reg.acc});
    end

    // Frame assembly: the rest of the CRC and the fixed trailer.
    always_comb
    begin
        logic [15:0] c;
        load_frame    = '0;
        load_frame[0] = SYNC_BYTE;
        load_frame[1] = device_address_reg;
        load_frame[2] = len_byte;
        for (int i = 0; i < 4; i++)
        begin
            load_frame[3 + i] = s3_reg.qb[i];
        end
        load_frame[7] = {6'b0, s3_reg.acc};
        c = s3_reg.crc;
        if (long_frame_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                load_frame[8 + 2 * i] = s3_reg.ang[i][7:0];
                load_frame[9 + 2 * i] = s3_reg.ang[i][15:8];
                c = crc_update(c, s3_reg.ang[i][7:0]);
                c = crc_update(c, s3_reg.ang[i][15:8]);
            end
            load_frame[14] = {7'b0, s3_reg.rev};
            c = crc_update(c, {7'b0, s3_reg.rev});
            load_frame[15] = c[15:8];
            load_frame[16] = c[7:0];
            load_frame[17] = TAIL_A;
            load_frame[18] = TAIL_B;
            load_cnt       = CNT_W'(FRAME_MAX);
        end
        else
        begin
            load_frame[8]  = PAD_BYTE;
            c = crc_update(c, PAD_BYTE);
            load_frame[9]  = c[15:8];
            load_frame[10] = c[7:0];
            load_frame[11] = TAIL_A;
            load_frame[12] = TAIL_B;
            load_cnt       = CNT_W'(FRAME_SHORT);
        end
    end

    // Output shift register: byte 0 is on the port, one byte moves per word taken.
    always_comb
    begin
        sh_next  = sh_reg;
        cnt_next = cnt_reg;
        if (s3_adv)
        begin
            sh_next  = load_frame;
            cnt_next = load_cnt;
        end
        else if (out_fire)
        begin
            for (int i = 0; i < FRAME_MAX - 1; i++)
            begin
                sh_next[i] = sh_reg[i + 1];
            end
            sh_next[FRAME_MAX-1] = PAD_BYTE;
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            cnt_reg      <= '0;
        end
        else
        begin
            if (s1_open)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_open)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_open)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_open)
        begin
            s1_reg <= s1_next;
        end
        if (s2_open)
        begin
            s2_reg <= s2_next;
        end
        if (s3_open)
        begin
            s3_reg <= s3_next;
        end
        sh_reg <= sh_next;
    end

endmodule

// File: hdl/afb_checker.sv
// Port-level checker for the attitude frame builder, bound to the top level.
`include "attitude_frame_builder_crc16_macros.svh"

module afb_checker
    import afb_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] frame_byte,
    input logic       last_byte
);

    // The closing word of every frame is the second tail byte.
    `AFB_ASSERT_SAME(a_last_is_tail,
        out_valid && last_byte,
        frame_byte == TAIL_B,
        "last word is not the tail byte")

    // A word that follows a finished frame opens the next one with the sync byte.
    `AFB_ASSERT_NEXT(a_sync_after_last,
        out_valid && out_ready && last_byte,
        !out_valid || frame_byte == SYNC_BYTE,
        "frame does not open with sync byte")

    // A stalled output word holds.
    `AFB_ASSERT_NEXT(a_out_hold,
        out_valid && !out_ready,
        out_valid && $stable(frame_byte) && $stable(last_byte),
        "stalled output word changed")

endmodule

bind attitude_frame_builder_crc16 afb_checker u_afb_checker (.*);

// File: bench/attitude_frame_builder_crc16_test.sv
// Self-checking bench for the attitude frame builder: predicts every framed byte and checks it.
`timescale 1ns / 1ps

module attitude_frame_builder_crc16_test;
    import afb_pkg::*;

    localparam int QUAT_PERCENT = 100;
    localparam int QUAT_ONE     = 16384;
    localparam int DEG_ONE      = 65536;
    localparam int ANGLE_MAX    = 11796480;
    localparam int HOLD_CYCLES  = 120;
    localparam int QUIET_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 10;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [15:0] qw;
        logic [15:0] qx;
        logic [15:0] qy;
        logic [15:0] qz;
        logic [24:0] ea;
        logic [24:0] eb;
        logic [24:0] ec;
        logic [1:0]  acc;
        logic        rev;
    } attitude_sample_t;

    // Builds the frame each sample should produce and checks the bytes as they leave.
    class attitude_frame_model;
        logic [7:0] dev_addr = 8'd1;
        logic       long_sel = 1'b0;
        logic [8:0] frame_bytes_due[$];
        int         errors = 0;
        int         frames_short = 0;
        int         frames_long = 0;
        int         frames_done = 0;
        int         bytes_checked = 0;

        function void set_register(cfg_index_t idx, logic [7:0] value);
            if (idx == CFG_DEVICE_ADDRESS)
            begin
                dev_addr = value;
            end
            else
            begin
                long_sel = value[0];
            end
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= REPORT_LIMIT)
            begin
                $display("%0t ERROR: %s", $time, msg);
            end
        endfunction

        function logic [7:0] quat_to_byte(logic [15:0] q);
            int v;
            v = $signed(q);
            v = (v * QUAT_PERCENT) / QUAT_ONE;
            return v[7:0];
        endfunction

        function logic [15:0] modbus_crc(logic [7:0] data[$]);
            logic [15:0] r;
            r = CRC_INIT;
            foreach (data[i])
            begin
                r ^= {8'h00, data[i]};
                repeat (8)
                begin
                    r = (r >> 1) ^ (r[0] ? CRC_POLY : 16'h0000);
                end
            end
            return r;
        endfunction

        function void take_sample(attitude_sample_t s);
            logic [7:0]  frame[$];
            logic [24:0] angles[3];
            logic [15:0] crc;
            int          deg;
            frame = {};
            angles[0] = s.ea;
            angles[1] = s.eb;
            angles[2] = s.ec;
            frame.push_back(SYNC_BYTE);
            frame.push_back(dev_addr);
            frame.push_back(long_sel ? LEN_LONG : LEN_SHORT);
            frame.push_back(quat_to_byte(s.qw));
            frame.push_back(quat_to_byte(s.qx));
            frame.push_back(quat_to_byte(s.qy));
            frame.push_back(quat_to_byte(s.qz));
            frame.push_back({6'b0, s.acc});
            if (long_sel)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    deg = $signed(angles[k]);
                    deg = deg / DEG_ONE;
                    frame.push_back(deg[7:0]);
                    frame.push_back(deg[15:8]);
                end
                frame.push_back({7'b0, s.rev});
                frames_long++;
            end
            else
            begin
                frame.push_back(PAD_BYTE);
                frames_short++;
            end
            crc = modbus_crc(frame);
            frame.push_back(crc[15:8]);
            frame.push_back(crc[7:0]);
            frame.push_back(TAIL_A);
            frame.push_back(TAIL_B);
            foreach (frame[i])
            begin
                frame_bytes_due.push_back({i == frame.size() - 1, frame[i]});
            end
        endfunction

        function void check_byte(logic [7:0] data, logic last);
            logic [8:0] want;
            if (frame_bytes_due.size() == 0)
            begin
                report($sformatf("byte %02h (last %0b) with no frame pending", data, last));
                return;
            end
            want = frame_bytes_due.pop_front();
            bytes_checked++;
            if (data !== want[7:0])
            begin
                report($sformatf("frame %0d: frame_byte expected %02h, got %02h",
                                 frames_done, want[7:0], data));
            end
            if (last !== want[8])
            begin
                report($sformatf("frame %0d: last_byte expected %0b, got %0b (byte %02h)",
                                 frames_done, want[8], last, want[7:0]));
            end
            if (want[8])
            begin
                frames_done++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    cfg_index_t        cfg_index;
    logic [7:0]        cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic [15:0]       quat_w;
    logic [15:0]       quat_x;
    logic [15:0]       quat_y;
    logic [15:0]       quat_z;
    logic [24:0]       euler_a;
    logic [24:0]       euler_b;
    logic [24:0]       euler_c;
    logic [1:0]        fusion_accuracy;
    logic              reverse_flag;
    logic              out_valid;
    logic              out_ready;
    logic [7:0]        frame_byte;
    logic              last_byte;

    attitude_frame_model frames = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int configs_applied = 0;

    attitude_frame_builder_crc16 dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .quat_w          (quat_w),
        .quat_x          (quat_x),
        .quat_y          (quat_y),
        .quat_z          (quat_z),
        .euler_a         (euler_a),
        .euler_b         (euler_b),
        .euler_c         (euler_c),
        .fusion_accuracy (fusion_accuracy),
        .reverse_flag    (reverse_flag),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .frame_byte      (frame_byte),
        .last_byte       (last_byte)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic attitude_sample_t make_sample(int w, int x, int y, int z,
                                                     int a, int b, int c, int acc, int rev);
        attitude_sample_t s;
        s.qw  = 16'(w);
        s.qx  = 16'(x);
        s.qy  = 16'(y);
        s.qz  = 16'(z);
        s.ea  = 25'(a);
        s.eb  = 25'(b);
        s.ec  = 25'(c);
        s.acc = 2'(acc);
        s.rev = 1'(rev);
        return s;
    endfunction

    // Mostly in-range values, with the range ends and raw bit patterns mixed in.
    function automatic logic [15:0] random_quat();
        case ($urandom_range(15))
            0: return 16'($urandom);
            1: return 16'(QUAT_ONE);
            2: return 16'(-QUAT_ONE);
            default: return 16'(int'($urandom_range(2 * QUAT_ONE)) - QUAT_ONE);
        endcase
    endfunction

    function automatic logic [24:0] random_angle();
        case ($urandom_range(15))
            0: return 25'($urandom);
            1: return 25'(ANGLE_MAX);
            2: return 25'(-ANGLE_MAX);
            3: return 25'(int'($urandom_range(2 * DEG_ONE)) - DEG_ONE);
            default: return 25'(int'($urandom_range(2 * ANGLE_MAX)) - ANGLE_MAX);
        endcase
    endfunction

    function automatic attitude_sample_t random_sample();
        attitude_sample_t s;
        s.qw  = random_quat();
        s.qx  = random_quat();
        s.qy  = random_quat();
        s.qz  = random_quat();
        s.ea  = random_angle();
        s.eb  = random_angle();
        s.ec  = random_angle();
        s.acc = 2'($urandom_range(3));
        s.rev = 1'($urandom_range(1));
        return s;
    endfunction

    // Offers one word and returns at the edge where it is taken.
    task automatic send_sample(input attitude_sample_t s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        quat_w          <= s.qw;
        quat_x          <= s.qx;
        quat_y          <= s.qy;
        quat_z          <= s.qz;
        euler_a         <= s.ea;
        euler_b         <= s.eb;
        euler_c         <= s.ec;
        fusion_accuracy <= s.acc;
        reverse_flag    <= s.rev;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        frames.take_sample(s);
    endtask

    task automatic send_random(input int count);
        repeat (count)
        begin
            send_sample(random_sample());
        end
    endtask

    // Drops valid and waits until every predicted byte has come out.
    task automatic drain();
        in_valid <= 1'b0;
        while (frames.frame_bytes_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [7:0] addr, input logic long_sel);
        logic [7:0] mode_word;
        mode_word = {7'($urandom), long_sel};
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DEVICE_ADDRESS;
        cfg_data  <= addr;
        @(posedge clk);
        cfg_index <= CFG_LONG_FRAME;
        cfg_data  <= mode_word;
        @(posedge clk);
        cfg_we    <= 1'b0;
        frames.set_register(CFG_DEVICE_ADDRESS, addr);
        frames.set_register(CFG_LONG_FRAME, mode_word);
        configs_applied++;
        @(posedge clk);
    endtask

    // Output side: random back-pressure, plus a long hold-off when one is requested.
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                frames.check_byte(frame_byte, last_byte);
            end
            if (hold_left == 0 && holds_served != hold_requests)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
            if (quiet >= QUIET_LIMIT)
            begin
                $display("FAIL attitude_frame_builder_crc16");
                $finish;
            end
        end
    end

    initial
    begin
        attitude_sample_t corner_samples[8];
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= CFG_DEVICE_ADDRESS;
        cfg_data        <= 8'h00;
        in_valid        <= 1'b0;
        quat_w          <= '0;
        quat_x          <= '0;
        quat_y          <= '0;
        quat_z          <= '0;
        euler_a         <= '0;
        euler_b         <= '0;
        euler_c         <= '0;
        fusion_accuracy <= '0;
        reverse_flag    <= 1'b0;

        // Range ends, raw 16-bit and 25-bit extremes, and values just either side of a
        // truncation step in both directions.
        corner_samples[0] = make_sample(0, 0, 0, 0, 0, 0, 0, 0, 0);
        corner_samples[1] = make_sample(QUAT_ONE, QUAT_ONE, QUAT_ONE, QUAT_ONE,
                                        ANGLE_MAX, ANGLE_MAX, ANGLE_MAX, 3, 1);
        corner_samples[2] = make_sample(-QUAT_ONE, -QUAT_ONE, -QUAT_ONE, -QUAT_ONE,
                                        -ANGLE_MAX, -ANGLE_MAX, -ANGLE_MAX, 2, 0);
        corner_samples[3] = make_sample(32767, -32768, 163, -164,
                                        16777215, -16777216, 0, 1, 1);
        corner_samples[4] = make_sample(-163, 164, 1, -1,
                                        -(DEG_ONE - 1), -DEG_ONE, DEG_ONE - 1, 0, 1);
        corner_samples[5] = make_sample(8192, -8192, QUAT_ONE - 1, 1 - QUAT_ONE,
                                        DEG_ONE, -1, 1, 3, 0);
        corner_samples[6] = make_sample(21845, -21846, 12345, -12345,
                                        11184810, -5592406, 5592405, 2, 1);
        corner_samples[7] = make_sample(-1, 65535 - 98304, 327, -328,
                                        -11141120, 11141120, -131073, 1, 0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 22;
        recv_idle_pct = 60;
        // Reset values first: address 1, short frame.
        foreach (corner_samples[i])
        begin
            send_sample(corner_samples[i]);
        end
        drain();
        configure(8'hFF, 1'b1);
        foreach (corner_samples[i])
        begin
            send_sample(corner_samples[i]);
        end
        drain();

        send_idle_pct = 60;
        recv_idle_pct = 22;
        configure(8'h00, 1'b0);
        send_random(50);
        drain();
        configure(8'($urandom), 1'b1);
        send_random(50);
        drain();

        // No idling; the receiver holds off so the pipeline backs up into the input.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure(8'($urandom), 1'b0);
        hold_requests <= hold_requests + 1;
        send_random(50);
        drain();
        configure(8'($urandom), 1'b1);
        hold_requests <= hold_requests + 1;
        send_random(50);
        drain();

        if (frames.frame_bytes_due.size() != 0)
        begin
            frames.report($sformatf("%0d predicted bytes never arrived",
                                    frames.frame_bytes_due.size()));
        end
        $display("Sent %0d short and %0d long frames over %0d register settings.",
                 frames.frames_short, frames.frames_long, configs_applied + 1);
        $display("Checked %0d bytes in %0d frames, including %0d receiver hold-offs.",
                 frames.bytes_checked, frames.frames_done, holds_served);
        if (frames.errors == 0)
        begin
            $display("PASS attitude_frame_builder_crc16");
        end
        else
        begin
            $display("%0d errors found.", frames.errors);
            $display("FAIL attitude_frame_builder_crc16");
        end
        $finish;
    end

endmodule
